### design/nfaec_pkg.sv
`default_nettype none
package nfaec_pkg;

	// Automaton size and derived widths
	localparam int NUM_STATES = 32;
	localparam int STATE_W    = $clog2(NUM_STATES);
	localparam int SIZE_W     = $clog2(NUM_STATES + 1);
	localparam int SYM_W      = 8;
	localparam int CMD_W      = 2;

	// Input beat layout, lowest bit first: cmd, from_state, symbol, to_state
	localparam int IN_BITS  = CMD_W + STATE_W + SYM_W + STATE_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = NUM_STATES + SIZE_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	localparam int FROM_LSB = CMD_W;
	localparam int SYM_LSB  = FROM_LSB + STATE_W;
	localparam int TO_LSB   = SYM_LSB + SYM_W;

	// Epsilon symbol after reset: letter e
	localparam logic [SYM_W-1:0] EPS_RESET = SYM_W'(101);

	// Commands
	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	typedef logic [NUM_STATES-1:0] state_mask_t;

endpackage
`default_nettype wire

### design/nfa_epsilon_closure.sv
// Channel   | Dir | Beat contents (lowest bit first)
// s_axis    | in  | cmd[1:0], from_state[6:2], symbol[14:7], to_state[19:15]
// m_axis    | out | closure_mask[31:0], closure_size[37:32]
// cfg       | in  | epsilon_symbol[7:0], written when cfg_we is high
//
// Add and clear give no result beat.
// A query expands one state per cycle until the closure (1 to 32 states) is done:
// the lowest pending state is picked and its edge row merged into the set, then
// the result is handed to the output register once that register is free.
// Input is not accepted while a query is expanding; the output register holds a
// finished result until m_axis_tready, and a later query's result waits for it to drain.
// arst_n clears the edge table and the control state and resets the epsilon symbol to e.
`default_nettype none
module nfa_epsilon_closure (
	input  wire                          clk,
	input  wire                          arst_n,
	// configuration
	input  wire                          cfg_we,
	input  wire [nfaec_pkg::SYM_W-1:0]   cfg_wdata,  // epsilon_symbol
	// input stream
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	input  wire [nfaec_pkg::IN_W-1:0]    s_axis_tdata,  // cmd, from_state, symbol, to_state
	// result stream
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	output logic [nfaec_pkg::OUT_W-1:0]  m_axis_tdata   // closure_mask, closure_size
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_EXPAND = 1'b1;

	logic                               state_q;
	logic [nfaec_pkg::SYM_W-1:0]        eps_sym_q;
	nfaec_pkg::state_mask_t             eps_edges_q [nfaec_pkg::NUM_STATES];
	nfaec_pkg::state_mask_t             visited_q;
	nfaec_pkg::state_mask_t             frontier_q;
	logic [nfaec_pkg::SIZE_W-1:0]       count_q;
	nfaec_pkg::state_mask_t             out_mask_q;
	logic [nfaec_pkg::SIZE_W-1:0]       out_size_q;
	logic                               out_valid_q;

	logic                               in_beat;
	logic [nfaec_pkg::CMD_W-1:0]        in_cmd;
	logic [nfaec_pkg::STATE_W-1:0]      in_from;
	logic [nfaec_pkg::SYM_W-1:0]        in_sym;
	logic [nfaec_pkg::STATE_W-1:0]      in_to;
	nfaec_pkg::state_mask_t             pick;
	nfaec_pkg::state_mask_t             row;
	logic                               out_free;
	logic                               done;

	// Field unpacking
	assign in_cmd  = s_axis_tdata[nfaec_pkg::CMD_W-1:0];
	assign in_from = s_axis_tdata[nfaec_pkg::FROM_LSB +: nfaec_pkg::STATE_W];
	assign in_sym  = s_axis_tdata[nfaec_pkg::SYM_LSB +: nfaec_pkg::SYM_W];
	assign in_to   = s_axis_tdata[nfaec_pkg::TO_LSB +: nfaec_pkg::STATE_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;
	assign out_free      = !out_valid_q || m_axis_tready;
	assign done          = (state_q == ST_EXPAND) && (frontier_q == '0) && out_free;

	// Expansion unit: isolate lowest pending state, fetch its edge row
	always_comb begin
		pick = frontier_q & (~frontier_q + nfaec_pkg::state_mask_t'(1));
		row  = '0;
		for (int i = 0; i < nfaec_pkg::NUM_STATES; i++) begin
			if (pick[i]) begin
				row = row | eps_edges_q[i];
			end
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_sym_q <= nfaec_pkg::EPS_RESET;
		end else if (cfg_we) begin
			eps_sym_q <= cfg_wdata;
		end
	end

	// Edge table: add sets one bit when its symbol is the epsilon symbol, clear wipes all rows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < nfaec_pkg::NUM_STATES; i++) begin
				eps_edges_q[i] <= '0;
			end
		end else if (in_beat) begin
			if (in_cmd == nfaec_pkg::CMD_CLEAR) begin
				for (int i = 0; i < nfaec_pkg::NUM_STATES; i++) begin
					eps_edges_q[i] <= '0;
				end
			end else if (in_cmd == nfaec_pkg::CMD_ADD && in_sym == eps_sym_q) begin
				eps_edges_q[in_from][in_to] <= 1'b1;
			end
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && in_cmd == nfaec_pkg::CMD_QUERY) begin
						state_q <= ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Closure datapath: one state expanded per cycle, count tracks expansions
	always_ff @(posedge clk) begin
		if (in_beat && in_cmd == nfaec_pkg::CMD_QUERY) begin
			visited_q  <= nfaec_pkg::state_mask_t'(1) << in_from;
			frontier_q <= nfaec_pkg::state_mask_t'(1) << in_from;
			count_q    <= '0;
		end else if (state_q == ST_EXPAND && frontier_q != '0) begin
			visited_q  <= visited_q | row;
			frontier_q <= (frontier_q & ~pick) | (row & ~visited_q);
			count_q    <= count_q + nfaec_pkg::SIZE_W'(1);
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_mask_q <= visited_q;
			out_size_q <= count_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = nfaec_pkg::OUT_W'({out_size_q, out_mask_q});

endmodule
`default_nettype wire
